### rtl/core/ofc_pkg.sv
// shared types and constants of the one-time-programmable fuse controller
package ofc_pkg;

    // bus access kinds
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;

    // bus responses
    localparam logic [1:0] RESP_OK    = 2'd0;
    localparam logic [1:0] RESP_BURST = 2'd1;
    localparam logic [1:0] RESP_BE    = 2'd2;
    localparam logic [1:0] RESP_CMD   = 2'd3;

    // register byte offsets
    localparam logic [11:0] OFF_CTRL        = 12'h000;
    localparam logic [11:0] OFF_STATUS      = 12'h004;
    localparam logic [11:0] OFF_ADDR        = 12'h008;
    localparam logic [11:0] OFF_WDATA       = 12'h00C;
    localparam logic [11:0] OFF_RDATA       = 12'h010;
    localparam logic [11:0] OFF_LOCK        = 12'h014;
    localparam logic [11:0] OFF_READ_LOCK   = 12'h018;
    localparam logic [11:0] OFF_ERR_STATUS  = 12'h01C;
    localparam logic [11:0] OFF_INTR_ENABLE = 12'h020;
    localparam logic [11:0] OFF_INTR_STATE  = 12'h024;
    localparam logic [11:0] OFF_SIZE_WORDS  = 12'h028;
    localparam logic [11:0] OFF_PART_SIZE   = 12'h02C;

    // control register bits
    localparam int CTRL_READ  = 0;
    localparam int CTRL_PROG  = 1;
    localparam int CTRL_CLEAR = 2;

    // error codes
    localparam logic [2:0] EC_CLEAR     = 3'd0;
    localparam logic [2:0] EC_ACCESS    = 3'd1;
    localparam logic [2:0] EC_BYTE_EN   = 3'd2;
    localparam logic [2:0] EC_RANGE     = 3'd3;
    localparam logic [2:0] EC_RD_LOCKED = 3'd4;
    localparam logic [2:0] EC_WR_LOCKED = 3'd5;
    localparam logic [2:0] EC_SET_ONLY  = 3'd6;

    localparam int PARTITIONS = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture an accepted access
        logic exec;   // carry out the captured access
        logic clear;  // zero one array word during the post-reset sweep
    } t_dp_cmd;

endpackage

### rtl/core/ofc_ctrl.sv
// controller state machine: post-reset clearing sweep and access sequencing
module ofc_ctrl
    import ofc_pkg::*;
#(
    parameter int WORDS = 256,
    parameter int IDX_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output t_dp_cmd          o_cmd,
    output logic [IDX_W-1:0] o_clr_idx
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] n_clr_idx;

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        o_cmd.clear = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_clr_idx   = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_clr_idx = r_clr_idx;

endmodule

### rtl/core/ofc_datapath.sv
// datapath: register file, fuse array, lock checks and result registers
module ofc_datapath
    import ofc_pkg::*;
#(
    parameter int WORDS     = 256,
    parameter int PART_SPAN = 64,
    parameter int IDX_W     = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [IDX_W-1:0] i_clr_idx,
    input  logic [1:0]       i_action,
    input  logic [11:0]      i_reg_offset,
    input  logic [31:0]      i_write_data,
    input  logic             i_size_is_word,
    input  logic             i_has_byte_enables,
    output logic             o_valid,
    output logic [31:0]      o_read_data,
    output logic [1:0]       o_response,
    output logic             o_irq_level
);

    logic [31:0] r_mem [WORDS];
    logic [31:0] r_mem_q;

    // captured access
    logic [1:0]  r_action;
    logic [11:0] r_offset;
    logic [31:0] r_wdata;
    logic        r_is_word;
    logic        r_has_be;

    // architectural registers
    logic [31:0] r_ctrl,  n_ctrl;
    logic [31:0] r_addr,  n_addr;
    logic [31:0] r_pdata, n_pdata;
    logic [31:0] r_rdres, n_rdres;
    logic [31:0] r_wlock, n_wlock;
    logic [31:0] r_rlock, n_rlock;
    logic [2:0]  r_err,   n_err;
    logic        r_done,  n_done;
    logic        r_error, n_error;
    logic        r_ien,   n_ien;
    logic        r_pend,  n_pend;

    logic        r_valid;
    logic [31:0] r_read_data;
    logic [1:0]  r_response;
    logic        r_irq_level;

    logic [31:0] rdata;
    logic [1:0]  resp;
    logic        mem_we;
    logic [31:0] mem_wdata;
    logic [IDX_W-1:0] idx;

    logic [PARTITIONS:0] ge;
    logic addr_bad;
    logic rd_locked;
    logic wr_locked;

    assign idx = r_addr[IDX_W-1:0];

    // thermometer of partition boundaries, one compare per boundary
    always_comb begin
        for (int p = 0; p <= PARTITIONS; p++) begin
            ge[p] = (r_addr >= 32'(p * PART_SPAN));
        end
    end

    assign addr_bad  = (r_addr >= 32'(WORDS));
    assign rd_locked = ge[PARTITIONS]
                     | (|(r_rlock & ge[PARTITIONS-1:0] & ~ge[PARTITIONS:1]));
    assign wr_locked = ge[PARTITIONS]
                     | (|(r_wlock & ge[PARTITIONS-1:0] & ~ge[PARTITIONS:1]));

    always_comb begin
        n_ctrl    = r_ctrl;
        n_addr    = r_addr;
        n_pdata   = r_pdata;
        n_rdres   = r_rdres;
        n_wlock   = r_wlock;
        n_rlock   = r_rlock;
        n_err     = r_err;
        n_done    = r_done;
        n_error   = r_error;
        n_ien     = r_ien;
        n_pend    = r_pend;
        rdata     = '0;
        resp      = RESP_OK;
        mem_we    = 1'b0;
        mem_wdata = r_mem_q | r_pdata;

        if (!r_is_word) begin
            resp    = RESP_BURST;
            n_err   = EC_ACCESS;
            n_error = 1'b1;
            n_pend  = 1'b1;
        end else if (r_has_be) begin
            resp    = RESP_BE;
            n_err   = EC_BYTE_EN;
            n_error = 1'b1;
            n_pend  = 1'b1;
        end else if (r_action == ACT_READ) begin
            case (r_offset)
                OFF_CTRL:        rdata = r_ctrl;
                OFF_STATUS:      rdata = {28'd0, r_pend, r_error, r_done, 1'b0};
                OFF_ADDR:        rdata = r_addr;
                OFF_WDATA:       rdata = r_pdata;
                OFF_RDATA:       rdata = r_rdres;
                OFF_LOCK:        rdata = r_wlock;
                OFF_READ_LOCK:   rdata = r_rlock;
                OFF_ERR_STATUS:  rdata = {29'd0, r_err};
                OFF_INTR_ENABLE: rdata = {31'd0, r_ien};
                OFF_INTR_STATE:  rdata = {31'd0, r_pend};
                OFF_SIZE_WORDS:  rdata = 32'(WORDS);
                OFF_PART_SIZE:   rdata = 32'(PART_SPAN);
                default: begin
                    n_err   = EC_ACCESS;
                    n_error = 1'b1;
                    n_pend  = 1'b1;
                end
            endcase
        end else if (r_action == ACT_WRITE) begin
            case (r_offset)
                OFF_CTRL: begin
                    n_ctrl = r_wdata;
                    if (r_wdata[CTRL_CLEAR]) begin
                        n_pend = 1'b0;
                    end
                    if (r_wdata[CTRL_READ]) begin
                        n_done  = 1'b0;
                        n_error = 1'b0;
                        n_err   = EC_CLEAR;
                        if (addr_bad) begin
                            n_err   = EC_RANGE;
                            n_error = 1'b1;
                            n_pend  = 1'b1;
                        end else if (rd_locked) begin
                            n_err   = EC_RD_LOCKED;
                            n_error = 1'b1;
                            n_pend  = 1'b1;
                        end else begin
                            n_rdres = r_mem_q;
                            n_done  = 1'b1;
                            n_pend  = 1'b1;
                        end
                    end
                    // program sees the word as it was before this transfer
                    if (r_wdata[CTRL_PROG]) begin
                        n_done  = 1'b0;
                        n_error = 1'b0;
                        n_err   = EC_CLEAR;
                        if (addr_bad) begin
                            n_err   = EC_RANGE;
                            n_error = 1'b1;
                            n_pend  = 1'b1;
                        end else if (wr_locked) begin
                            n_err   = EC_WR_LOCKED;
                            n_error = 1'b1;
                            n_pend  = 1'b1;
                        end else if ((r_mem_q & ~r_pdata) != '0) begin
                            n_err   = EC_SET_ONLY;
                            n_error = 1'b1;
                            n_pend  = 1'b1;
                        end else begin
                            mem_we = 1'b1;
                            n_done = 1'b1;
                            n_pend = 1'b1;
                        end
                    end
                end
                OFF_ADDR:      n_addr  = r_wdata;
                OFF_WDATA:     n_pdata = r_wdata;
                OFF_LOCK:      n_wlock = r_wlock | r_wdata;
                OFF_READ_LOCK: n_rlock = r_rlock | r_wdata;
                OFF_ERR_STATUS: begin
                    if (r_wdata != '0) begin
                        n_err   = EC_CLEAR;
                        n_error = 1'b0;
                    end
                end
                OFF_INTR_ENABLE: n_ien = r_wdata[0];
                OFF_INTR_STATE: begin
                    if (r_wdata[0]) begin
                        n_pend = 1'b0;
                    end
                end
                default: begin
                    n_err   = EC_ACCESS;
                    n_error = 1'b1;
                    n_pend  = 1'b1;
                end
            endcase
        end else begin
            resp    = RESP_CMD;
            n_err   = EC_ACCESS;
            n_error = 1'b1;
            n_pend  = 1'b1;
        end
    end

    // fuse array: one write port, registered read at the current word address
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[i_clr_idx] <= '0;
        end else if (i_cmd.exec && mem_we) begin
            r_mem[idx] <= mem_wdata;
        end
        r_mem_q <= r_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_offset  <= i_reg_offset;
            r_wdata   <= i_write_data;
            r_is_word <= i_size_is_word;
            r_has_be  <= i_has_byte_enables;
        end
        if (i_cmd.exec) begin
            r_read_data <= rdata;
            r_response  <= resp;
            r_irq_level <= n_ien & n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= '0;
            r_addr  <= '0;
            r_pdata <= '0;
            r_rdres <= '0;
            r_wlock <= '0;
            r_rlock <= '0;
            r_err   <= EC_CLEAR;
            r_done  <= 1'b0;
            r_error <= 1'b0;
            r_ien   <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_ctrl  <= n_ctrl;
                r_addr  <= n_addr;
                r_pdata <= n_pdata;
                r_rdres <= n_rdres;
                r_wlock <= n_wlock;
                r_rlock <= n_rlock;
                r_err   <= n_err;
                r_done  <= n_done;
                r_error <= n_error;
                r_ien   <= n_ien;
                r_pend  <= n_pend;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_read_data;
    assign o_response  = r_response;
    assign o_irq_level = r_irq_level;

endmodule

### rtl/core/otp_fuse_controller_top.sv
// top level of the one-time-programmable fuse controller
// sequencing: an accepted transfer moves the controller to its execute state, which
// loads the result registers and raises the result strobe
// a new transfer is not accepted while the last one is in its execute state, with
// busy high
// reset: the architectural registers and the result strobe clear at once, then a sweep
// zeroes every array word with busy high; the receiver cannot stall, each result shows for one cycle
module otp_fuse_controller_top
    import ofc_pkg::*;
#(
    parameter int WORDS     = 256,
    parameter int PART_SPAN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_reg_offset,
    input  logic [31:0] i_write_data,
    input  logic        i_size_is_word,
    input  logic        i_has_byte_enables,
    output logic        o_valid,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_response,
    output logic        o_irq_level
);

    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_dp_cmd          cmd;
    logic [IDX_W-1:0] clr_idx;

    ofc_ctrl #(
        .WORDS (WORDS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_cmd     (cmd),
        .o_clr_idx (clr_idx)
    );

    ofc_datapath #(
        .WORDS     (WORDS),
        .PART_SPAN (PART_SPAN),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_clr_idx          (clr_idx),
        .i_action           (i_action),
        .i_reg_offset       (i_reg_offset),
        .i_write_data       (i_write_data),
        .i_size_is_word     (i_size_is_word),
        .i_has_byte_enables (i_has_byte_enables),
        .o_valid            (o_valid),
        .o_read_data        (o_read_data),
        .o_response         (o_response),
        .o_irq_level        (o_irq_level)
    );

    // an accepted transfer is carried out in the execute state, then strobed in the cycle after
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && cmd.exec) ##1 o_valid)
        else $error("accepted transfer did not produce its result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_response != RESP_OK) |-> (o_read_data == '0))
        else $error("rejected transfer returned read data");

    a_no_clear_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !cmd.clear)
        else $error("array sweep active while idle");

endmodule

### sim/tb_otp_fuse_controller_top.sv
`timescale 1ns / 100ps
// testbench of the fuse controller: directed and random bus accesses checked against a predictor
module tb_otp_fuse_controller_top;
    import ofc_pkg::*;

    localparam int FUSE_WORDS     = 256;
    localparam int FUSE_PART_SPAN = 64;
    localparam int STALL_LIMIT    = 4000;

    // status register bit positions
    localparam int STAT_DONE  = 1;
    localparam int STAT_ERROR = 2;
    localparam int STAT_IRQ   = 3;

    // unsupported bus commands
    localparam logic [1:0] ACT_OTHER    = 2'd2;
    localparam logic [1:0] ACT_OTHER_HI = 2'd3;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  response;
        logic        irq_level;
    } t_bus_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [11:0] i_reg_offset;
    logic [31:0] i_write_data;
    logic        i_size_is_word;
    logic        i_has_byte_enables;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic [1:0]  o_response;
    logic        o_irq_level;

    otp_fuse_controller_top #(
        .WORDS     (FUSE_WORDS),
        .PART_SPAN (FUSE_PART_SPAN)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_reg_offset       (i_reg_offset),
        .i_write_data       (i_write_data),
        .i_size_is_word     (i_size_is_word),
        .i_has_byte_enables (i_has_byte_enables),
        .o_valid            (o_valid),
        .o_read_data        (o_read_data),
        .o_response         (o_response),
        .o_irq_level        (o_irq_level)
    );

    t_bus_resp   expected_resps[$];
    int          fail_count      = 0;
    int          accesses        = 0;
    int          sender_idle_pct = 0;
    int          stall_cycles    = 0;
    bit          locks_unmasked  = 1'b0;

    // predicted register and array state
    logic [31:0] fuse_words [FUSE_WORDS];
    logic [31:0] ctrl_reg;
    logic [3:0]  status_reg;
    logic [31:0] addr_reg;
    logic [31:0] wdata_reg;
    logic [31:0] rdata_reg;
    logic [31:0] wlock_mask;
    logic [31:0] rlock_mask;
    logic [2:0]  err_code;
    logic        irq_en;
    logic        irq_pend;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void flag_error(logic [2:0] code);
        err_code               = code;
        status_reg[STAT_ERROR] = 1'b1;
        status_reg[STAT_IRQ]   = 1'b1;
        irq_pend               = 1'b1;
    endfunction

    function automatic void flag_done();
        status_reg[STAT_DONE] = 1'b1;
        status_reg[STAT_IRQ]  = 1'b1;
        irq_pend              = 1'b1;
    endfunction

    function automatic void clear_irq();
        irq_pend             = 1'b0;
        status_reg[STAT_IRQ] = 1'b0;
    endfunction

    // common checks of an array operation, returns 0 when it is refused
    function automatic bit fuse_op_allowed(logic [31:0] mask, logic [2:0] lock_err);
        int part;
        status_reg[STAT_DONE]  = 1'b0;
        status_reg[STAT_ERROR] = 1'b0;
        err_code               = EC_CLEAR;
        if (addr_reg >= FUSE_WORDS) begin
            flag_error(EC_RANGE);
            return 1'b0;
        end
        part = addr_reg / FUSE_PART_SPAN;
        if (part >= PARTITIONS) begin
            flag_error(lock_err);
            return 1'b0;
        end
        if (mask[part]) begin
            flag_error(lock_err);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void fuse_read_op();
        if (!fuse_op_allowed(rlock_mask, EC_RD_LOCKED))
            return;
        rdata_reg = fuse_words[addr_reg];
        flag_done();
    endfunction

    function automatic void fuse_program_op();
        logic [31:0] old_word;
        if (!fuse_op_allowed(wlock_mask, EC_WR_LOCKED))
            return;
        old_word = fuse_words[addr_reg];
        if ((old_word & ~wdata_reg) != 32'd0) begin
            flag_error(EC_SET_ONLY);
            return;
        end
        fuse_words[addr_reg] = old_word | wdata_reg;
        flag_done();
    endfunction

    function automatic logic [31:0] reg_read_value(logic [11:0] off);
        case (off)
            OFF_CTRL:        return ctrl_reg;
            OFF_STATUS:      return {28'd0, status_reg};
            OFF_ADDR:        return addr_reg;
            OFF_WDATA:       return wdata_reg;
            OFF_RDATA:       return rdata_reg;
            OFF_LOCK:        return wlock_mask;
            OFF_READ_LOCK:   return rlock_mask;
            OFF_ERR_STATUS:  return {29'd0, err_code};
            OFF_INTR_ENABLE: return {31'd0, irq_en};
            OFF_INTR_STATE:  return {31'd0, irq_pend};
            OFF_SIZE_WORDS:  return FUSE_WORDS;
            OFF_PART_SIZE:   return FUSE_PART_SPAN;
            default: begin
                flag_error(EC_ACCESS);
                return 32'd0;
            end
        endcase
    endfunction

    function automatic void reg_write_effect(logic [11:0] off, logic [31:0] v);
        case (off)
            OFF_CTRL: begin
                // clear, then read, then program
                ctrl_reg = v;
                if (v[CTRL_CLEAR])
                    clear_irq();
                if (v[CTRL_READ])
                    fuse_read_op();
                if (v[CTRL_PROG])
                    fuse_program_op();
            end
            OFF_ADDR:      addr_reg = v;
            OFF_WDATA:     wdata_reg = v;
            OFF_LOCK:      wlock_mask |= v;
            OFF_READ_LOCK: rlock_mask |= v;
            OFF_ERR_STATUS: begin
                if (v != 32'd0) begin
                    err_code               = EC_CLEAR;
                    status_reg[STAT_ERROR] = 1'b0;
                end
            end
            OFF_INTR_ENABLE: irq_en = v[0];
            OFF_INTR_STATE: begin
                if (v[0])
                    clear_irq();
            end
            default: flag_error(EC_ACCESS);
        endcase
    endfunction

    function automatic t_bus_resp predict_access(logic [1:0] act, logic [11:0] off,
                                                 logic [31:0] data, logic word, logic be);
        t_bus_resp r;
        r.read_data = 32'd0;
        r.response  = RESP_OK;
        if (!word) begin
            r.response = RESP_BURST;
            flag_error(EC_ACCESS);
        end else if (be) begin
            r.response = RESP_BE;
            flag_error(EC_BYTE_EN);
        end else if (act == ACT_READ) begin
            r.read_data = reg_read_value(off);
        end else if (act == ACT_WRITE) begin
            reg_write_effect(off, data);
        end else begin
            r.response = RESP_CMD;
            flag_error(EC_ACCESS);
        end
        r.irq_level = irq_en & irq_pend;
        return r;
    endfunction

    // one bus access, with a random idle gap ahead of it
    task automatic bus_access(input logic [1:0] act, input logic [11:0] off,
                              input logic [31:0] data, input logic word, input logic be);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        start              <= 1'b1;
        i_action           <= act;
        i_reg_offset       <= off;
        i_write_data       <= data;
        i_size_is_word     <= word;
        i_has_byte_enables <= be;
        do @(posedge i_clk); while (busy);
        expected_resps.push_back(predict_access(act, off, data, word, be));
        accesses++;
    endtask

    task automatic reg_wr(input logic [11:0] off, input logic [31:0] data);
        bus_access(ACT_WRITE, off, data, 1'b1, 1'b0);
    endtask

    task automatic reg_rd(input logic [11:0] off);
        bus_access(ACT_READ, off, $urandom, 1'b1, 1'b0);
    endtask

    task automatic wait_responses_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_resps.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        reg_rd(OFF_STATUS);
        reg_rd(OFF_SIZE_WORDS);
        reg_rd(OFF_PART_SIZE);
    endtask

    task automatic test_fuse_program_read();
        reg_wr(OFF_INTR_ENABLE, 32'd1);
        reg_wr(OFF_ADDR, 32'd0);
        reg_wr(OFF_WDATA, 32'hFFFF_FFFF);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_PROG);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_READ);
        reg_rd(OFF_RDATA);
        // clearing programmed bits is refused
        reg_wr(OFF_WDATA, 32'd0);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_PROG);
        reg_rd(OFF_ERR_STATUS);
        reg_wr(OFF_ADDR, FUSE_WORDS - 1);
        reg_wr(OFF_WDATA, 32'h8000_0001);
        reg_wr(OFF_CTRL, 32'h7);
        reg_rd(OFF_STATUS);
        reg_wr(OFF_INTR_STATE, 32'd1);
        reg_wr(OFF_ADDR, FUSE_WORDS);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_READ);
        reg_wr(OFF_ADDR, 32'hFFFF_FFFF);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_PROG);
    endtask

    task automatic test_bus_errors();
        bus_access(ACT_READ, OFF_STATUS, 32'd0, 1'b0, 1'b1);
        bus_access(ACT_WRITE, OFF_CTRL, 32'hFFFF_FFFF, 1'b1, 1'b1);
        bus_access(ACT_OTHER, OFF_ADDR, 32'd0, 1'b1, 1'b0);
        bus_access(ACT_OTHER_HI, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        reg_rd(12'h030);
        reg_wr(12'h001, 32'h1234_5678);
        reg_wr(OFF_STATUS, 32'hF);
        reg_wr(OFF_SIZE_WORDS, 32'd0);
        reg_rd(12'hFFF);
        reg_wr(OFF_ERR_STATUS, 32'd0);
        reg_wr(OFF_ERR_STATUS, 32'd1);
    endtask

    // address, data, control, then a look at the outcome and at times a write to the interrupt state
    task automatic run_fuse_op();
        logic [31:0] addr;
        logic [31:0] data;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            addr = $urandom_range(0, FUSE_WORDS - 1);
        else if (pick < 95)
            addr = $urandom_range(FUSE_WORDS, 4 * FUSE_WORDS);
        else
            addr = $urandom;
        reg_wr(OFF_ADDR, addr);
        if (addr < FUSE_WORDS && $urandom_range(0, 99) < 75)
            data = fuse_words[addr] | ($urandom & $urandom & $urandom);
        else
            data = $urandom;
        reg_wr(OFF_WDATA, data);
        reg_wr(OFF_CTRL, ($urandom & ~32'h7) | $urandom_range(1, 7));
        pick = $urandom_range(0, 99);
        if (pick < 55)
            reg_rd(OFF_RDATA);
        else if (pick < 80)
            reg_rd(OFF_STATUS);
        else
            reg_rd(OFF_ERR_STATUS);
        if ($urandom_range(0, 99) < 25)
            reg_wr(OFF_INTR_STATE, $urandom);
    endtask

    task automatic send_noise();
        logic [11:0] off;
        logic [31:0] data;
        off  = 12'($urandom_range(0, 11) * 4);
        data = $urandom;
        case ($urandom_range(0, 9))
            0: bus_access(2'($urandom), 12'($urandom), $urandom, 1'b0, 1'($urandom));
            1: bus_access(2'($urandom), 12'($urandom), $urandom, 1'b1, 1'b1);
            2: bus_access(2'($urandom_range(ACT_OTHER, ACT_OTHER_HI)), 12'($urandom),
                          $urandom, 1'b1, 1'b0);
            3: bus_access(2'($urandom_range(ACT_READ, ACT_WRITE)), 12'($urandom),
                          $urandom, 1'b1, 1'b0);
            4, 5, 6: reg_rd(off);
            default: begin
                // keep the low partitions open until the lock test
                if ((off inside {OFF_LOCK, OFF_READ_LOCK}) && !locks_unmasked)
                    data = data & ~32'hF;
                else if (off == OFF_ADDR && $urandom_range(0, 9) != 0)
                    data = $urandom_range(0, FUSE_WORDS - 1);
                reg_wr(off, data);
            end
        endcase
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        stop_at = accesses + count;
        while (accesses < stop_at) begin
            if ($urandom_range(0, 99) < 55)
                run_fuse_op();
            else
                send_noise();
        end
    endtask

    task automatic test_partition_locks();
        reg_wr(OFF_LOCK, 32'h2);
        reg_wr(OFF_READ_LOCK, 32'h4);
        reg_wr(OFF_ADDR, FUSE_PART_SPAN + 6);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_PROG);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_READ);
        reg_wr(OFF_ADDR, 2 * FUSE_PART_SPAN + 3);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_READ);
        reg_wr(OFF_CTRL, 32'd1 << CTRL_PROG);
        reg_rd(OFF_ERR_STATUS);
        reg_rd(OFF_LOCK);
        reg_rd(OFF_READ_LOCK);
        locks_unmasked = 1'b1;
        test_random_traffic(120);
    endtask

    always @(posedge i_clk) begin : result_check
        t_bus_resp want;
        if (i_rst_n && o_valid) begin
            if (expected_resps.size() == 0) begin
                $error("unexpected result transfer: read_data %h response %0d irq_level %0d",
                       o_read_data, o_response, o_irq_level);
                fail_count++;
            end else begin
                want = expected_resps.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, o_read_data);
                    fail_count++;
                end
                if (o_response !== want.response) begin
                    $error("response: expected %0d, got %0d", want.response, o_response);
                    fail_count++;
                end
                if (o_irq_level !== want.irq_level) begin
                    $error("irq_level: expected %0d, got %0d", want.irq_level, o_irq_level);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        start              <= 1'b0;
        i_action           <= ACT_READ;
        i_reg_offset       <= OFF_CTRL;
        i_write_data       <= 32'd0;
        i_size_is_word     <= 1'b1;
        i_has_byte_enables <= 1'b0;
        i_rst_n            <= 1'b0;
        foreach (fuse_words[i])
            fuse_words[i] = 32'd0;
        ctrl_reg   = 32'd0;
        status_reg = 4'd0;
        addr_reg   = 32'd0;
        wdata_reg  = 32'd0;
        rdata_reg  = 32'd0;
        wlock_mask = 32'd0;
        rlock_mask = 32'd0;
        err_code   = EC_CLEAR;
        irq_en     = 1'b0;
        irq_pend   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_fuse_program_read();
        test_bus_errors();
        test_random_traffic(450);
        wait_responses_drained();
        sender_idle_pct = 63;
        test_random_traffic(430);
        sender_idle_pct = 28;
        test_random_traffic(330);
        sender_idle_pct = 0;
        test_partition_locks();

        wait_responses_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_resps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
